[hdl/rida_pkg.sv]
// ----------------------------------------------------------------------------
// rida_pkg
// shared types and constants of the rolling id allocator
// ----------------------------------------------------------------------------
package rida_pkg;

   localparam int ID_W             = 16;
   localparam int MAX_VALUE_DEF    = 65536;
   localparam int CAPACITY_DEF     = 64;

   localparam logic OP_ACQUIRE     = 1'b0;
   localparam logic OP_FREE        = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACQ,
      S_FREE_CMP,
      S_FREE_SHIFT
   } state_type;

   typedef struct packed {
      logic occupied;
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

[hdl/rida_cell.sv]
// ----------------------------------------------------------------------------
// rida_cell
// one slot of the identifier store: holds a value, matches it against the
// broadcast key and takes its upper neighbor's value when the row closes a gap
// ----------------------------------------------------------------------------
module rida_cell (
   input  logic                        clock,
   input  rida_pkg::cell_ctrl_type     ctrl,
   input  logic [rida_pkg::ID_W-1:0]   key,
   input  logic [rida_pkg::ID_W-1:0]   shift_value,
   output logic [rida_pkg::ID_W-1:0]   value,
   output logic                        hit
);

   logic [rida_pkg::ID_W-1:0] val_ff;
   logic [rida_pkg::ID_W-1:0] val_in;

   always_comb begin
      val_in = val_ff;
      if (ctrl.load) begin
         val_in = key;
      end else if (ctrl.shift) begin
         val_in = shift_value;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign value = val_ff;
   assign hit   = ctrl.occupied && (val_ff == key);

endmodule

[hdl/rolling_unique_id_allocator_top.sv]
// ----------------------------------------------------------------------------
// rolling_unique_id_allocator_top
// hands out unique identifiers from a rolling counter and takes them back
// ----------------------------------------------------------------------------
// Identifiers in use live in a row of CAPACITY cells that all compare against
// one broadcast key each cycle. An acquire tries candidates from the rolling
// counter, moving to the next while one is already in use; a free compares,
// closes the gap by shifting the upper cells down, and responds.
// One word is worked on at a time; req_stall stays high until the result is
// written to the output register, which holds it while rsp_stall is high.
module rolling_unique_id_allocator_top #(
   parameter int MAX_VALUE = rida_pkg::MAX_VALUE_DEF,
   parameter int CAPACITY  = rida_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [rida_pkg::ID_W-1:0]   req_number,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rida_pkg::ID_W-1:0]   rsp_id_value,
   output logic [1:0]                  rsp_status
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = $clog2(CAPACITY);
   localparam int IW = rida_pkg::ID_W;

   rida_pkg::state_type state_ff, state_in;

   logic [IW-1:0]       counter_ff;
   logic [IW-1:0]       cand_ff;
   logic [IW-1:0]       number_ff;
   logic [CW-1:0]       count_ff;
   logic                found_ff;
   logic [XW-1:0]       hit_idx_ff;
   logic [XW-1:0]       hit_idx_in;

   logic                rsp_valid_ff;
   logic [IW-1:0]       rsp_id_ff;
   rida_pkg::status_type rsp_status_ff;

   logic [IW-1:0]       key;
   logic [CAPACITY-1:0] hit_vec;
   logic [IW-1:0]       cell_value [CAPACITY];
   logic                any_hit;
   logic                full;
   logic                out_free;
   logic                finish;
   logic                advance;
   logic                cand_load;
   logic                acq_ok;

   function automatic logic [IW-1:0] next_cand(input logic [IW-1:0] c);
      logic [IW:0] sum;
      sum = {1'b0, c} + {{IW{1'b0}}, 1'b1};
      if (sum >= (IW+1)'(MAX_VALUE)) begin
         next_cand = {{(IW-1){1'b0}}, 1'b1};
      end else begin
         next_cand = sum[IW-1:0];
      end
   endfunction

   assign key      = (state_ff == rida_pkg::S_ACQ) ? cand_ff : number_ff;
   assign any_hit  = |hit_vec;
   assign full     = (count_ff == CW'(CAPACITY));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // cell row
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      rida_pkg::cell_ctrl_type ctrl;
      logic [IW-1:0]           up_value;

      if (k == CAPACITY - 1) begin : g_last
         assign up_value = cell_value[k];
      end else begin : g_mid
         assign up_value = cell_value[k+1];
      end

      assign ctrl.occupied = (CW'(k) < count_ff);
      assign ctrl.load     = acq_ok && (count_ff == CW'(k));
      assign ctrl.shift    = (state_ff == rida_pkg::S_FREE_SHIFT) && found_ff && out_free
                             && (XW'(k) >= hit_idx_ff);

      rida_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .key         (key),
         .shift_value (up_value),
         .value       (cell_value[k]),
         .hit         (hit_vec[k])
      );
   end

   always_comb begin
      hit_idx_in = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if (hit_vec[k]) begin
            hit_idx_in = hit_idx_in | XW'(k);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rida_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = (req_operation == rida_pkg::OP_ACQUIRE) ?
                          rida_pkg::S_ACQ : rida_pkg::S_FREE_CMP;
            end
         end
         rida_pkg::S_ACQ: begin
            if ((full || !any_hit) && out_free) begin
               state_in = rida_pkg::S_IDLE;
            end
         end
         rida_pkg::S_FREE_CMP: begin
            state_in = rida_pkg::S_FREE_SHIFT;
         end
         rida_pkg::S_FREE_SHIFT: begin
            if (out_free) begin
               state_in = rida_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rida_pkg::S_IDLE;
         end
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_stall = 1'b1;
      finish    = 1'b0;
      advance   = 1'b0;
      cand_load = 1'b0;
      acq_ok    = 1'b0;
      case (state_ff)
         rida_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cand_load = req_valid;
         end
         rida_pkg::S_ACQ: begin
            advance = !full && any_hit;
            finish  = (full || !any_hit) && out_free;
            acq_ok  = !full && !any_hit && out_free;
         end
         rida_pkg::S_FREE_SHIFT: begin
            finish = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rida_pkg::S_IDLE;
         counter_ff   <= {{(IW-1){1'b0}}, 1'b1};
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (acq_ok) begin
            counter_ff <= cand_ff;
            count_ff   <= count_ff + CW'(1);
         end else if (state_ff == rida_pkg::S_FREE_SHIFT && finish && found_ff) begin
            count_ff <= count_ff - CW'(1);
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cand_load) begin
         cand_ff   <= next_cand(counter_ff);
         number_ff <= req_number;
      end else if (advance) begin
         cand_ff <= next_cand(cand_ff);
      end
      if (state_ff == rida_pkg::S_FREE_CMP) begin
         found_ff   <= any_hit;
         hit_idx_ff <= hit_idx_in;
      end
      if (finish) begin
         if (state_ff == rida_pkg::S_ACQ) begin
            rsp_id_ff     <= full ? '0 : cand_ff;
            rsp_status_ff <= full ? rida_pkg::ST_FULL : rida_pkg::ST_OK;
         end else begin
            rsp_id_ff     <= '0;
            rsp_status_ff <= found_ff ? rida_pkg::ST_OK : rida_pkg::ST_UNKNOWN;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_id_value = rsp_id_ff;
   assign rsp_status   = rsp_status_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("store count above capacity");

   a_acq_grows: assert property (@(posedge clock) disable iff (reset)
      acq_ok |=> count_ff == $past(count_ff) + CW'(1))
      else $error("acquire did not grow the store");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == rida_pkg::S_ACQ
                               || $past(state_ff) == rida_pkg::S_FREE_SHIFT))
      else $error("response raised outside a finishing state");

   a_acq_unique: assert property (@(posedge clock) disable iff (reset)
      acq_ok |-> !any_hit && cand_ff != '0)
      else $error("acquired identifier already in use");

endmodule

[test/id_allocator_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id_allocator_checker
// watches both channels of the rolling id allocator, predicts each result
// word from its own copy of the counter and the store of identifiers in use,
// and compares every result word field by field in order of acceptance
// ----------------------------------------------------------------------------
module id_allocator_checker #(
   parameter int MAX_VALUE = rida_pkg::MAX_VALUE_DEF,
   parameter int CAPACITY  = rida_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_operation,
   input  logic [rida_pkg::ID_W-1:0] req_number,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [rida_pkg::ID_W-1:0] rsp_id_value,
   input  logic [1:0]                rsp_status,
   output int                        fail_count,
   output int                        open_count
);

   typedef struct packed {
      logic [rida_pkg::ID_W-1:0] id_value;
      rida_pkg::status_type      status;
   } reply_type;

   int                        roll_ctr;
   logic [rida_pkg::ID_W-1:0] held_ids[$];
   reply_type                 due_replies[$];

   function automatic reply_type grant_or_release(
      input logic                      op,
      input logic [rida_pkg::ID_W-1:0] number);
      reply_type r;
      int        hit_at;
      bit        taken;
      r.id_value = '0;
      r.status   = rida_pkg::ST_OK;
      if (op == rida_pkg::OP_ACQUIRE) begin
         if (held_ids.size() >= CAPACITY) begin
            r.status = rida_pkg::ST_FULL;
         end else begin
            for (int t = 0; t <= CAPACITY + 1; t++) begin
               roll_ctr = roll_ctr + 1;
               if (roll_ctr >= MAX_VALUE) begin
                  roll_ctr = 1;
               end
               taken = 1'b0;
               foreach (held_ids[k]) begin
                  if (held_ids[k] == roll_ctr) taken = 1'b1;
               end
               if (!taken) break;
            end
            held_ids.push_back(rida_pkg::ID_W'(roll_ctr));
            r.id_value = rida_pkg::ID_W'(roll_ctr);
         end
      end else begin
         hit_at = -1;
         foreach (held_ids[k]) begin
            if (hit_at < 0 && held_ids[k] == number) hit_at = k;
         end
         if (hit_at < 0) begin
            r.status = rida_pkg::ST_UNKNOWN;
         end else begin
            held_ids.delete(hit_at);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reply_type want;
      if (reset) begin
         roll_ctr   = 1;
         fail_count = 0;
         held_ids.delete();
         due_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               $error("result word with nothing expected: id_value %0d, status %0d",
                      rsp_id_value, rsp_status);
               fail_count++;
            end else begin
               want = due_replies.pop_front();
               if (rsp_id_value !== want.id_value) begin
                  $error("id_value mismatch: expected %0d, actual %0d",
                         want.id_value, rsp_id_value);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_replies.push_back(grant_or_release(req_operation, req_number));
         end
      end
      open_count = due_replies.size();
   end

endmodule

[test/tb_rolling_unique_id_allocator_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rolling_unique_id_allocator_top
// drives acquire and free words into the rolling id allocator: a short
// directed opening, a fill to a full store and a thinning of it, then random
// traffic that swings between filling and emptying the store
// ----------------------------------------------------------------------------
module tb_rolling_unique_id_allocator_top;

   localparam int QUIET_LIMIT  = 4000;
   localparam int HELD_FLOOR   = 40;
   localparam int STEADY_WORDS = 300;
   localparam int RANDOM_WORDS = 1350;

   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_operation = rida_pkg::OP_ACQUIRE;
   logic [rida_pkg::ID_W-1:0] req_number    = '0;
   logic                      rsp_stall     = 1'b0;
   logic                      jitter_on     = 1'b1;
   logic                      req_stall;
   logic                      rsp_valid;
   logic [rida_pkg::ID_W-1:0] rsp_id_value;
   logic [1:0]                rsp_status;

   int                        fail_count;
   int                        open_count;
   int                        sent_count = 0;
   int                        rsp_count  = 0;
   logic [rida_pkg::ID_W-1:0] live_ids[$];

   initial begin
      forever #5 clock = ~clock;
   end

   rolling_unique_id_allocator_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_number    (req_number),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_id_value  (rsp_id_value),
      .rsp_status    (rsp_status)
   );

   id_allocator_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_number    (req_number),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_id_value  (rsp_id_value),
      .rsp_status    (rsp_status),
      .fail_count    (fail_count),
      .open_count    (open_count)
   );

   always @(posedge clock) begin
      rsp_stall <= jitter_on && ($urandom_range(99) < 16);
   end

   // waits for a clock edge, collecting granted ids from the result channel
   task automatic advance();
      @(posedge clock);
      if (rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (rsp_id_value != '0) live_ids.push_back(rsp_id_value);
      end
   endtask

   task automatic send_word(input logic op, input logic [rida_pkg::ID_W-1:0] number);
      while (jitter_on && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         advance();
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_number    <= number;
      advance();
      while (req_stall) advance();
      sent_count++;
   endtask

   task automatic free_at(input int idx);
      logic [rida_pkg::ID_W-1:0] number;
      number = live_ids[idx];
      live_ids.delete(idx);
      send_word(rida_pkg::OP_FREE, number);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do advance(); while (rsp_count < sent_count);
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("rolling_unique_id_allocator_top verification failed");
      $finish;
   end

   initial begin : stimulus
      int n;
      int roll;
      int acq_pct;
      repeat (4) advance();
      reset <= 1'b0;

      // opening words on an empty store
      send_word(rida_pkg::OP_FREE, '0);
      send_word(rida_pkg::OP_ACQUIRE, '1);
      send_word(rida_pkg::OP_ACQUIRE, '0);
      send_word(rida_pkg::OP_ACQUIRE, 16'h5A5A);
      send_word(rida_pkg::OP_FREE, '1);
      send_word(rida_pkg::OP_FREE, 16'd1);
      drain();
      free_at(1);
      send_word(rida_pkg::OP_FREE, 16'd3);
      send_word(rida_pkg::OP_ACQUIRE, 16'hA5A5);
      free_at(0);
      send_word(rida_pkg::OP_FREE, 16'h8000);
      drain();

      // fill to full, then thin out to a scattered set of held ids
      jitter_on <= 1'b0;
      n = rida_pkg::CAPACITY_DEF - live_ids.size();
      repeat (n) send_word(rida_pkg::OP_ACQUIRE, rida_pkg::ID_W'($urandom));
      repeat (2) send_word(rida_pkg::OP_ACQUIRE, rida_pkg::ID_W'($urandom));
      drain();
      while (live_ids.size() > HELD_FLOOR) free_at($urandom_range(live_ids.size() - 1));
      drain();

      // random traffic alternating between growing and shrinking the store
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n == STEADY_WORDS) jitter_on <= 1'b1;
         acq_pct = ((n / 150) % 2 == 0) ? 70 : 25;
         roll    = $urandom_range(99);
         if (roll < 8) begin
            send_word(rida_pkg::OP_FREE, rida_pkg::ID_W'($urandom));
         end else if (roll < 8 + acq_pct || live_ids.size() == 0) begin
            send_word(rida_pkg::OP_ACQUIRE, rida_pkg::ID_W'($urandom));
         end else begin
            free_at($urandom_range(live_ids.size() - 1));
         end
      end

      drain();
      repeat (100) advance();
      if (fail_count == 0 && open_count == 0) begin
         $display("rolling_unique_id_allocator_top verification clean");
      end else begin
         $display("rolling_unique_id_allocator_top verification failed");
      end
      $finish;
   end

endmodule
